// ----- hw/rtl/ddr_pkg.sv -----
// ----------------------------------------------------------------------------
// ddr_pkg
// Types and constants shared by the deadlock detection and resolution block.
// ----------------------------------------------------------------------------
package ddr_pkg;

    localparam int OPCODE_W   = 3;
    localparam int THREAD_W   = 4;
    localparam int RESOURCE_W = 3;
    localparam int AMOUNT_W   = 16;
    localparam int SET_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int TCOUNT_W   = 5;
    localparam int RCOUNT_W   = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_AVAIL = 3'd0,
        OP_SET_CLAIM = 3'd1,
        OP_ACQUIRE   = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_DETECT    = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREAD_COUNT   = 2'd0,
        CFG_RESOURCE_COUNT = 2'd1,
        CFG_VICTIM_POLICY  = 2'd2
    } t_cfg_idx;

    localparam logic [TCOUNT_W-1:0] THREAD_COUNT_RST   = 5'd16;
    localparam logic [RCOUNT_W-1:0] RESOURCE_COUNT_RST = 4'd8;
    localparam logic                VICTIM_POLICY_RST  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_ACQ_EV,
        S_REL_RD,
        S_REL_EV,
        S_EMP_RD,
        S_EMP_EV,
        S_FIT_SEL,
        S_FIT_RD,
        S_FIT_EV,
        S_ADD_RD,
        S_ADD_EV,
        S_VIC_SEL,
        S_VIC_RD,
        S_VIC_EV,
        S_VIC_END,
        S_FREE_RD,
        S_FREE_EV,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/ddr_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ddr_cmd_if
// Command channel carrying one operation word per handshake.
// ----------------------------------------------------------------------------
interface ddr_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [ddr_pkg::OPCODE_W-1:0]    opcode;
    logic [ddr_pkg::THREAD_W-1:0]    thread_id;
    logic [ddr_pkg::RESOURCE_W-1:0]  resource_id;
    logic [ddr_pkg::AMOUNT_W-1:0]    amount;

    modport source (output valid, opcode, thread_id, resource_id, amount, input ready);
    modport sink   (input valid, opcode, thread_id, resource_id, amount, output ready);
endinterface

// ----- hw/rtl/ddr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ddr_rsp_if
// Response channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
interface ddr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic                          deadlock_found;
    logic [ddr_pkg::SET_W-1:0]     deadlocked_set;
    logic [ddr_pkg::THREAD_W-1:0]  victim;

    modport source (output valid, granted, deadlock_found, deadlocked_set, victim,
                    input ready);
    modport sink   (input valid, granted, deadlock_found, deadlocked_set, victim,
                    output ready);
endinterface

// ----- hw/rtl/ddr_ram.sv -----
// ----------------------------------------------------------------------------
// ddr_ram
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module ddr_ram #(
    parameter int AW = 7,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hw/rtl/deadlock_detection_resolver.sv -----
// ----------------------------------------------------------------------------
// deadlock_detection_resolver
// Tracks available, held and claimed resource units, detects deadlock and frees a victim.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd and each produces exactly one result word on o_rsp.
// The held and claim matrices live in two single-port memories addressed by
// thread and resource; each entry read passes through the registered memory
// output before an evaluate state uses it, which sets the latency.
// Release walks every resource in use. Detect walks the memories: one emptiness
// pass, repeated claim checks per thread, one sum pass and a victim release.
// One command is worked on at a time; the next is taken once the result sits
// in the output register, so a stalled receiver holds at most one finished
// word and blocks further commands only when a second result is ready.
// After reset the block sweeps all MAX_THREADS * MAX_RESOURCES entries of both
// memories to zero, one entry a cycle, with i_cmd.ready low. Configuration
// writes on i_cfg_we are taken at any time and must be issued while idle.
// ----------------------------------------------------------------------------
module deadlock_detection_resolver #(
    parameter int MAX_THREADS   = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ddr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ddr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    ddr_cmd_if.sink                          i_cmd,
    ddr_rsp_if.source                        o_rsp
);
    localparam int TW  = $clog2(MAX_THREADS);
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int NTW = $clog2(MAX_THREADS + 1);
    localparam int NRW = $clog2(MAX_RESOURCES + 1);
    localparam int CW  = COUNT_WIDTH;
    localparam int SW  = COUNT_WIDTH + $clog2(MAX_RESOURCES) + 1;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    ddr_pkg::t_state r_state, n_state;
    ddr_pkg::t_op    r_op, n_op;
    logic [TW-1:0]   r_t, n_t;
    logic [RW-1:0]   r_r, n_r;
    logic [CW-1:0]   r_amt, n_amt;
    logic            r_tok, n_tok, r_rok, n_rok;
    logic [ddr_pkg::TCOUNT_W-1:0] r_thread_count;
    logic [ddr_pkg::RCOUNT_W-1:0] r_resource_count;
    logic            r_policy;
    logic [CW-1:0]   r_avail [MAX_RESOURCES];
    logic [CW-1:0]   n_avail [MAX_RESOURCES];
    logic [CW-1:0]   r_work  [MAX_RESOURCES];
    logic [CW-1:0]   n_work  [MAX_RESOURCES];
    logic [MAX_THREADS-1:0] r_fin, n_fin, r_dead, n_dead;
    logic            r_granted, n_granted, r_found, n_found;
    logic            r_any, n_any, r_nonempty, n_nonempty, r_fits, n_fits;
    logic [TW-1:0]   r_best, n_best;
    logic [SW-1:0]   r_bsum, n_bsum, r_sum, n_sum, total;
    logic            r_ov, rsp_load;

    logic            we_h, we_c;
    logic [CW-1:0]   wd_h, wd_c, rd_h, rd_c;
    logic [NTW-1:0]  nt;
    logic [NRW-1:0]  nr;
    logic            last_r, last_t, better;

    ddr_ram #(.AW(TW + RW), .DW(CW)) u_held (
        .i_clk(i_clk), .i_we(we_h), .i_addr({r_t, r_r}), .i_wdata(wd_h), .o_rdata(rd_h)
    );
    ddr_ram #(.AW(TW + RW), .DW(CW)) u_claim (
        .i_clk(i_clk), .i_we(we_c), .i_addr({r_t, r_r}), .i_wdata(wd_c), .o_rdata(rd_c)
    );

    always_comb begin
        nt = (32'(r_thread_count) > MAX_THREADS) ? NTW'(MAX_THREADS) : NTW'(r_thread_count);
        nr = (32'(r_resource_count) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES)
                                                      : NRW'(r_resource_count);
        last_r = (32'(r_r) + 1) == 32'(nr);
        last_t = (32'(r_t) + 1) == 32'(nt);
        total  = r_sum + SW'(rd_h);
        better = !r_any || (r_policy ? (total >= r_bsum) : (total <= r_bsum));
    end

    always_comb begin
        n_state = r_state;  n_op = r_op;  n_t = r_t;  n_r = r_r;  n_amt = r_amt;
        n_tok = r_tok;  n_rok = r_rok;  n_avail = r_avail;  n_work = r_work;
        n_fin = r_fin;  n_dead = r_dead;  n_granted = r_granted;  n_found = r_found;
        n_any = r_any;  n_nonempty = r_nonempty;  n_fits = r_fits;
        n_best = r_best;  n_bsum = r_bsum;  n_sum = r_sum;
        we_h = 1'b0;  we_c = 1'b0;  wd_h = '0;  wd_c = '0;
        i_cmd.ready = 1'b0;  rsp_load = 1'b0;
        unique case (r_state)
            ddr_pkg::S_CLEAR: begin
                we_h = 1'b1;
                we_c = 1'b1;
                if (32'(r_r) == MAX_RESOURCES - 1) begin
                    n_r = '0;
                    if (32'(r_t) == MAX_THREADS - 1) begin
                        n_t     = '0;
                        n_state = ddr_pkg::S_IDLE;
                    end else begin
                        n_t = r_t + 1'b1;
                    end
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            ddr_pkg::S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_op    = ddr_pkg::t_op'(i_cmd.opcode);
                    n_t     = TW'(i_cmd.thread_id);
                    n_r     = RW'(i_cmd.resource_id);
                    n_amt   = CW'(i_cmd.amount);
                    n_tok   = 32'(i_cmd.thread_id) < 32'(nt);
                    n_rok   = 32'(i_cmd.resource_id) < 32'(nr);
                    n_state = ddr_pkg::S_DEC;
                end
            end
            ddr_pkg::S_DEC: begin
                n_granted = 1'b0;
                n_found   = 1'b0;
                n_dead    = '0;
                n_any     = 1'b0;
                n_state   = ddr_pkg::S_DONE;
                unique case (r_op)
                    ddr_pkg::OP_SET_AVAIL: begin
                        if (r_rok) begin
                            n_avail[r_r] = r_amt;
                        end
                    end
                    ddr_pkg::OP_SET_CLAIM: begin
                        if (r_tok && r_rok) begin
                            we_c = 1'b1;
                            wd_c = r_amt;
                        end
                    end
                    ddr_pkg::OP_ACQUIRE: begin
                        if (r_tok && r_rok) begin
                            n_state = ddr_pkg::S_ACQ_EV;
                        end
                    end
                    ddr_pkg::OP_RELEASE: begin
                        if (r_tok && nr != '0) begin
                            n_r     = '0;
                            n_state = ddr_pkg::S_REL_RD;
                        end
                    end
                    ddr_pkg::OP_DETECT: begin
                        n_work     = r_avail;
                        n_fin      = '0;
                        n_t        = '0;
                        n_r        = '0;
                        n_nonempty = 1'b0;
                        if (nt != '0 && nr != '0) begin
                            n_state = ddr_pkg::S_EMP_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ddr_pkg::S_ACQ_EV: begin
                if (r_amt <= r_avail[r_r]) begin
                    n_avail[r_r] = r_avail[r_r] - r_amt;
                    we_h = 1'b1;
                    we_c = 1'b1;
                    wd_h = sat_add(rd_h, r_amt);
                    wd_c = (rd_c > r_amt) ? rd_c - r_amt : '0;
                    n_granted = 1'b1;
                end
                n_state = ddr_pkg::S_DONE;
            end
            ddr_pkg::S_REL_RD: n_state = ddr_pkg::S_REL_EV;
            ddr_pkg::S_REL_EV: begin
                n_avail[r_r] = sat_add(r_avail[r_r], rd_h);
                we_h = 1'b1;
                we_c = 1'b1;
                if (last_r) begin
                    n_state = ddr_pkg::S_DONE;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = ddr_pkg::S_REL_RD;
                end
            end
            ddr_pkg::S_EMP_RD: n_state = ddr_pkg::S_EMP_EV;
            ddr_pkg::S_EMP_EV: begin
                if (last_r) begin
                    n_fin[r_t] = !(r_nonempty || rd_h != '0);
                    n_nonempty = 1'b0;
                    n_r        = '0;
                    if (last_t) begin
                        n_t     = TW'(nt - 1'b1);
                        n_state = ddr_pkg::S_FIT_SEL;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = ddr_pkg::S_EMP_RD;
                    end
                end else begin
                    n_nonempty = r_nonempty || rd_h != '0;
                    n_r        = r_r + 1'b1;
                    n_state    = ddr_pkg::S_EMP_RD;
                end
            end
            ddr_pkg::S_FIT_SEL: begin
                n_r = '0;
                if (!r_fin[r_t]) begin
                    n_fits  = 1'b1;
                    n_state = ddr_pkg::S_FIT_RD;
                end else if (r_t == '0) begin
                    n_state = ddr_pkg::S_VIC_SEL;
                end else begin
                    n_t = r_t - 1'b1;
                end
            end
            ddr_pkg::S_FIT_RD: n_state = ddr_pkg::S_FIT_EV;
            ddr_pkg::S_FIT_EV: begin
                n_fits = r_fits && (rd_c <= r_work[r_r]);
                if (!last_r) begin
                    n_r     = r_r + 1'b1;
                    n_state = ddr_pkg::S_FIT_RD;
                end else if (n_fits) begin
                    n_r     = '0;
                    n_state = ddr_pkg::S_ADD_RD;
                end else if (r_t == '0) begin
                    n_state = ddr_pkg::S_VIC_SEL;
                end else begin
                    n_t     = r_t - 1'b1;
                    n_state = ddr_pkg::S_FIT_SEL;
                end
            end
            ddr_pkg::S_ADD_RD: n_state = ddr_pkg::S_ADD_EV;
            ddr_pkg::S_ADD_EV: begin
                n_work[r_r] = sat_add(r_work[r_r], rd_h);
                if (last_r) begin
                    n_fin[r_t] = 1'b1;
                    n_t        = TW'(nt - 1'b1);
                    n_state    = ddr_pkg::S_FIT_SEL;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = ddr_pkg::S_ADD_RD;
                end
            end
            ddr_pkg::S_VIC_SEL: begin
                n_r   = '0;
                n_sum = '0;
                if (!r_fin[r_t]) begin
                    n_state = ddr_pkg::S_VIC_RD;
                end else if (last_t) begin
                    n_state = ddr_pkg::S_VIC_END;
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            ddr_pkg::S_VIC_RD: n_state = ddr_pkg::S_VIC_EV;
            ddr_pkg::S_VIC_EV: begin
                n_sum = total;
                if (!last_r) begin
                    n_r     = r_r + 1'b1;
                    n_state = ddr_pkg::S_VIC_RD;
                end else begin
                    n_dead[r_t] = 1'b1;
                    if (better) begin
                        n_best = r_t;
                        n_bsum = total;
                        n_any  = 1'b1;
                    end
                    if (last_t) begin
                        n_state = ddr_pkg::S_VIC_END;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = ddr_pkg::S_VIC_SEL;
                    end
                end
            end
            ddr_pkg::S_VIC_END: begin
                n_r = '0;
                if (r_any) begin
                    n_t     = r_best;
                    n_state = ddr_pkg::S_FREE_RD;
                end else begin
                    n_state = ddr_pkg::S_DONE;
                end
            end
            ddr_pkg::S_FREE_RD: n_state = ddr_pkg::S_FREE_EV;
            ddr_pkg::S_FREE_EV: begin
                n_avail[r_r] = sat_add(r_avail[r_r], rd_h);
                n_work[r_r]  = sat_add(r_work[r_r], rd_h);
                we_h = 1'b1;
                we_c = 1'b1;
                if (last_r) begin
                    n_fin[r_t] = 1'b1;
                    n_found    = 1'b1;
                    n_state    = ddr_pkg::S_DONE;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = ddr_pkg::S_FREE_RD;
                end
            end
            ddr_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    rsp_load = 1'b1;
                    n_state  = ddr_pkg::S_IDLE;
                end
            end
            default: n_state = ddr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ddr_pkg::S_CLEAR;
            r_t              <= '0;
            r_r              <= '0;
            r_ov             <= 1'b0;
            r_thread_count   <= ddr_pkg::THREAD_COUNT_RST;
            r_resource_count <= ddr_pkg::RESOURCE_COUNT_RST;
            r_policy         <= ddr_pkg::VICTIM_POLICY_RST;
            r_fin            <= '0;
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_avail[i] <= '0;
                r_work[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_r     <= n_r;
            r_avail <= n_avail;
            r_work  <= n_work;
            r_fin   <= n_fin;
            if (rsp_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (ddr_pkg::t_cfg_idx'(i_cfg_index))
                    ddr_pkg::CFG_THREAD_COUNT:   r_thread_count   <= i_cfg_wdata;
                    ddr_pkg::CFG_RESOURCE_COUNT: r_resource_count <= i_cfg_wdata[ddr_pkg::RCOUNT_W-1:0];
                    ddr_pkg::CFG_VICTIM_POLICY:  r_policy         <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_amt      <= n_amt;
        r_tok      <= n_tok;
        r_rok      <= n_rok;
        r_dead     <= n_dead;
        r_granted  <= n_granted;
        r_found    <= n_found;
        r_any      <= n_any;
        r_nonempty <= n_nonempty;
        r_fits     <= n_fits;
        r_best     <= n_best;
        r_bsum     <= n_bsum;
        r_sum      <= n_sum;
        if (rsp_load) begin
            o_rsp.granted        <= r_granted;
            o_rsp.deadlock_found <= r_found;
            o_rsp.deadlocked_set <= r_found ? ddr_pkg::SET_W'(r_dead) : '0;
            o_rsp.victim         <= r_found ? ddr_pkg::THREAD_W'(r_best) : '0;
        end
    end

    assign o_rsp.valid = r_ov;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddr_pkg::S_CLEAR |-> !i_cmd.ready)
        else $error("command taken during memory clear");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_state == ddr_pkg::S_DEC)
        else $error("accepted command not decoded");
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.granted && o_rsp.deadlock_found))
        else $error("grant and deadlock reported together");
`endif
endmodule

// ----- tb/sv/deadlock_detection_resolver_tb.sv -----
// ----------------------------------------------------------------------------
// deadlock_detection_resolver_tb
// Self-checking bench for the deadlock detection and resolution block. It
// predicts every result word in a scoreboard that keeps its own copy of the
// available, held and claim stores. It drives directed corner cases and then
// random resource scenarios under several thread and resource counts and
// both victim policies, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module deadlock_detection_resolver_tb;

    localparam int NT_MAX  = 16;
    localparam int NR_MAX  = 8;
    localparam int CNT_MAX = 65535;

    typedef struct packed {
        logic        granted;
        logic        found;
        logic [15:0] dead_set;
        logic [3:0]  victim;
    } t_rsp_word;

    class deadlock_scoreboard;
        int unsigned thread_cnt = 16;
        int unsigned resource_cnt = 8;
        bit          kill_largest = 1'b1;
        int unsigned avail [NR_MAX];
        int unsigned held [NT_MAX][NR_MAX];
        int unsigned claim [NT_MAX][NR_MAX];
        int unsigned work [NR_MAX];
        t_rsp_word   pending [$];
        int          errors = 0;
        int          checked = 0;
        int          deadlocks = 0;
        int          grants = 0;

        function int unsigned sat_add(int unsigned a, int unsigned b);
            return (a + b > CNT_MAX) ? CNT_MAX : a + b;
        endfunction

        function int unsigned nt();
            return thread_cnt > NT_MAX ? NT_MAX : thread_cnt;
        endfunction

        function int unsigned nr();
            return resource_cnt > NR_MAX ? NR_MAX : resource_cnt;
        endfunction

        function void set_register(ddr_pkg::t_cfg_idx idx, logic [4:0] value);
            case (idx)
                ddr_pkg::CFG_THREAD_COUNT: begin
                    thread_cnt = value;
                end
                ddr_pkg::CFG_RESOURCE_COUNT: begin
                    resource_cnt = value[3:0];
                end
                ddr_pkg::CFG_VICTIM_POLICY: begin
                    kill_largest = value[0];
                end
                default: begin
                end
            endcase
        endfunction

        function void free_thread(int t, bit into_work);
            for (int r = 0; r < nr(); r++) begin
                avail[r] = sat_add(avail[r], held[t][r]);
                if (into_work) work[r] = sat_add(work[r], held[t][r]);
                held[t][r] = 0;
                claim[t][r] = 0;
            end
        endfunction

        function void run_detect(ref t_rsp_word w);
            logic [NT_MAX-1:0] done_mask;
            bit progress;
            bit any;
            bit fits;
            int best;
            int unsigned best_sum;
            int unsigned sum;
            done_mask = '0;
            any = 0;
            best = 0;
            best_sum = 0;
            for (int r = 0; r < nr(); r++) work[r] = avail[r];
            for (int t = 0; t < nt(); t++) begin
                done_mask[t] = 1'b1;
                for (int r = 0; r < nr(); r++)
                    if (held[t][r] != 0) done_mask[t] = 1'b0;
            end
            progress = 1;
            while (progress) begin
                progress = 0;
                for (int t = nt() - 1; t >= 0 && !progress; t--) begin
                    if (!done_mask[t]) begin
                        fits = 1;
                        for (int r = 0; r < nr(); r++)
                            if (claim[t][r] > work[r]) fits = 0;
                        if (fits) begin
                            for (int r = 0; r < nr(); r++)
                                work[r] = sat_add(work[r], held[t][r]);
                            done_mask[t] = 1'b1;
                            progress = 1;
                        end
                    end
                end
            end
            for (int t = 0; t < nt(); t++) begin
                if (!done_mask[t]) begin
                    w.dead_set[t] = 1'b1;
                    sum = 0;
                    for (int r = 0; r < nr(); r++) sum += held[t][r];
                    if (!any || (kill_largest ? sum >= best_sum : sum <= best_sum)) begin
                        best = t;
                        best_sum = sum;
                        any = 1;
                    end
                end
            end
            if (any) begin
                free_thread(best, 1);
                w.found = 1'b1;
                w.victim = best[3:0];
                deadlocks++;
            end
        endfunction

        function void note_command(logic [2:0] op, logic [3:0] tid, logic [2:0] rid,
                                   logic [15:0] amt);
            t_rsp_word w;
            bit t_ok;
            bit r_ok;
            w = '0;
            t_ok = tid < nt();
            r_ok = rid < nr();
            case (op)
                ddr_pkg::OP_SET_AVAIL: begin
                    if (r_ok) avail[rid] = amt;
                end
                ddr_pkg::OP_SET_CLAIM: begin
                    if (t_ok && r_ok) claim[tid][rid] = amt;
                end
                ddr_pkg::OP_ACQUIRE: begin
                    if (t_ok && r_ok && amt <= avail[rid]) begin
                        avail[rid] -= amt;
                        held[tid][rid] = sat_add(held[tid][rid], amt);
                        claim[tid][rid] = claim[tid][rid] > amt ? claim[tid][rid] - amt : 0;
                        w.granted = 1'b1;
                        grants++;
                    end
                end
                ddr_pkg::OP_RELEASE: begin
                    if (t_ok) free_thread(tid, 0);
                end
                ddr_pkg::OP_DETECT: begin
                    run_detect(w);
                end
                default: begin
                end
            endcase
            pending.push_back(w);
        endfunction

        function void check_result(t_rsp_word got);
            t_rsp_word exp_w;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.granted !== exp_w.granted) begin
                $error("granted: expected %0d, got %0d", exp_w.granted, got.granted);
                errors++;
            end
            if (got.found !== exp_w.found) begin
                $error("deadlock_found: expected %0d, got %0d", exp_w.found, got.found);
                errors++;
            end
            if (got.dead_set !== exp_w.dead_set) begin
                $error("deadlocked_set: expected %h, got %h", exp_w.dead_set, got.dead_set);
                errors++;
            end
            if (got.victim !== exp_w.victim) begin
                $error("victim: expected %0d, got %0d", exp_w.victim, got.victim);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ddr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ddr_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ddr_cmd_if cmd_ch ();
    ddr_rsp_if rsp_ch ();

    deadlock_detection_resolver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_rsp       (rsp_ch)
    );

    deadlock_scoreboard sb = new();
    int unsigned cycle_no = 0;
    int items_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    function automatic bit quiet_window();
        return cycle_no >= 3000 && cycle_no < 6000;
    endfunction

    function automatic bit take_gap();
        return !quiet_window() && $urandom_range(99) < 22;
    endfunction

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = '0;
        cmd_ch.thread_id = '0;
        cmd_ch.resource_id = '0;
        cmd_ch.amount = '0;
        rsp_ch.ready = 1'b0;
    end

    // The receiver stalls for a long stretch early on while commands keep coming.
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        forever begin
            @(negedge i_clk);
            if (rx_cycle >= 1500 && rx_cycle < 1900) rsp_ch.ready <= 1'b0;
            else rsp_ch.ready <= !take_gap();
            rx_cycle++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.granted, rsp_ch.deadlock_found,
                             rsp_ch.deadlocked_set, rsp_ch.victim});
    end

    task automatic send_word(logic [2:0] op, logic [3:0] tid, logic [2:0] rid,
                             logic [15:0] amt);
        @(negedge i_clk);
        while (take_gap()) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.thread_id <= tid;
        cmd_ch.resource_id <= rid;
        cmd_ch.amount <= amt;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(op, tid, rid, amt);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(ddr_pkg::t_cfg_idx idx, logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic configure(logic [4:0] tc, logic [4:0] rc, logic [4:0] pol);
        settle();
        write_register(ddr_pkg::CFG_THREAD_COUNT, tc);
        write_register(ddr_pkg::CFG_RESOURCE_COUNT, rc);
        write_register(ddr_pkg::CFG_VICTIM_POLICY, pol);
    endtask

    function automatic logic [15:0] pick_amount();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) return 16'($urandom_range(6));
        if (sel < 92) return 16'($urandom);
        return 16'hFFFF;
    endfunction

    // A scenario fills available counts and claims, lets threads acquire and
    // sometimes release, then asks for detection.
    task automatic run_scenario();
        int tn;
        int rn;
        tn = sb.nt() == 0 ? 1 : sb.nt();
        rn = sb.nr() == 0 ? 1 : sb.nr();
        for (int r = 0; r < rn; r++)
            send_word(ddr_pkg::OP_SET_AVAIL, '0, 3'(r), 16'($urandom_range(8)));
        for (int k = 0; k < tn + 2; k++)
            send_word(ddr_pkg::OP_SET_CLAIM, 4'($urandom_range(tn - 1)),
                      3'($urandom_range(rn - 1)), 16'($urandom_range(5)));
        for (int k = 0; k < tn + rn; k++)
            send_word(ddr_pkg::OP_ACQUIRE, 4'($urandom_range(tn - 1)),
                      3'($urandom_range(rn - 1)), 16'($urandom_range(3)));
        if ($urandom_range(3) == 0)
            send_word(ddr_pkg::OP_RELEASE, 4'($urandom_range(tn - 1)), '0, '0);
        send_word(ddr_pkg::OP_DETECT, 4'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic send_noise();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            send_word(3'($urandom_range(7, 5)), 4'($urandom), 3'($urandom), 16'($urandom));
        else if (sel < 45)
            send_word(ddr_pkg::OP_DETECT, 4'($urandom), 3'($urandom), 16'($urandom));
        else
            send_word(3'($urandom_range(3)), 4'($urandom), 3'($urandom), pick_amount());
    endtask

    task automatic random_phase(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(99) < 75) run_scenario();
            else send_noise();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(ddr_pkg::OP_SET_AVAIL, '0, 3'd7, 16'hFFFF);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd15, 3'd7, 16'hFFFF);
        send_word(ddr_pkg::OP_SET_AVAIL, '0, 3'd7, 16'hFFFF);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd15, 3'd7, 16'hFFFF);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd0, 3'd0, 16'd0);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd0, 3'd0, 16'd1);
        send_word(ddr_pkg::OP_RELEASE, 4'd15, '0, '0);
        send_word(ddr_pkg::OP_SET_AVAIL, '0, 3'd0, 16'd2);
        send_word(ddr_pkg::OP_SET_CLAIM, 4'd1, 3'd0, 16'd5);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd1, 3'd0, 16'd2);
        send_word(ddr_pkg::OP_SET_CLAIM, 4'd2, 3'd0, 16'd1);
        send_word(ddr_pkg::OP_SET_AVAIL, '0, 3'd1, 16'd1);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd2, 3'd1, 16'd1);
        send_word(ddr_pkg::OP_DETECT, '0, '0, '0);
        send_word(ddr_pkg::OP_SET_CLAIM, 4'd3, 3'd1, 16'hFFFF);
        send_word(ddr_pkg::OP_ACQUIRE, 4'd3, 3'd7, 16'd1);
        send_word(ddr_pkg::OP_DETECT, '0, '0, '0);
        send_word(3'd7, 4'd15, 3'd7, 16'hFFFF);
        send_word(3'd5, '0, '0, '0);

        configure(5'd4, 5'd2, 5'd0);
        random_phase(350);
        configure(5'd31, 5'd15, 5'd1);
        random_phase(60);
        configure(5'd0, 5'd0, 5'd0);
        for (int k = 0; k < 15; k++) send_noise();
        configure(5'd1, 5'd1, 5'd1);
        random_phase(150);
        configure(5'd3, 5'd3, 5'd0);
        random_phase(300);
        configure(5'd6, 5'd4, 5'd1);
        random_phase(250);
        configure(5'd16, 5'd8, 5'd0);
        random_phase(60);
        settle();
        repeat (50) @(posedge i_clk);

        $display("covered %0d command words, %0d result words, %0d grants, %0d deadlocks",
                 items_sent, sb.checked, sb.grants, sb.deadlocks);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d expected result words never arrived", sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
